>>> hdl/u8d_pkg.sv
package u8d_pkg;

   localparam int unsigned CP_W   = 21;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned BITS_W = 7;
   localparam int unsigned REM_W  = 2;

   // Result status codes.
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_ERROR = 1'b1;

   typedef enum logic [2:0] {
      CLS_ASCII,
      CLS_CONT,
      CLS_LEAD2,
      CLS_LEAD3,
      CLS_LEAD4,
      CLS_INVALID
   } byte_class_type;

   // One classified byte as it sits in the queue between front and back.
   typedef struct packed {
      byte_class_type      cls;
      logic [BITS_W-1:0]   bits;
      logic                eot;
   } token_type;

endpackage

>>> hdl/u8d_req_if.sv
interface u8d_req_if
   import u8d_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              end_of_text;

   modport source (output valid, output data_byte, output end_of_text, input ready);
   modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

>>> hdl/u8d_rsp_if.sv
interface u8d_rsp_if
   import u8d_pkg::*;
   ();
   logic            valid;
   logic            ready;
   logic [CP_W-1:0] code_point;
   logic            status;

   modport source (output valid, output code_point, output status, input ready);
   modport sink   (input valid, input code_point, input status, output ready);
endinterface

>>> hdl/u8d_classify.sv
module u8d_classify
   import u8d_pkg::*;
   (
   u8d_req_if.sink   req,
   input  logic      push_ready,
   output logic      push_valid,
   output token_type push_token
);

   logic [BYTE_W-1:0] b;

   assign b          = req.data_byte;
   assign push_valid = req.valid;
   assign req.ready  = push_ready;

   // The lead byte keeps only its payload bits; the prefix is folded into the class.
   always_comb begin
      push_token.eot = req.end_of_text;
      priority if (b[7] == 1'b0) begin
         push_token.cls  = CLS_ASCII;
         push_token.bits = b[6:0];
      end else if (b[7:6] == 2'b10) begin
         push_token.cls  = CLS_CONT;
         push_token.bits = {1'b0, b[5:0]};
      end else if (b[7:5] == 3'b110) begin
         push_token.cls  = CLS_LEAD2;
         push_token.bits = {2'b00, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
         push_token.cls  = CLS_LEAD3;
         push_token.bits = {3'b000, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
         push_token.cls  = CLS_LEAD4;
         push_token.bits = {4'b0000, b[2:0]};
      end else begin
         push_token.cls  = CLS_INVALID;
         push_token.bits = '0;
      end
   end

endmodule

>>> hdl/u8d_queue.sv
module u8d_queue
   import u8d_pkg::*;
   #(
   parameter int unsigned DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   input  token_type push_token,
   output logic      push_ready,
   output logic      pop_valid,
   output token_type pop_token,
   input  logic      pop
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   token_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_token  = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_token;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count exceeds depth");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !do_pop) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("queue count did not follow a push");

endmodule

>>> hdl/u8d_assemble.sv
module u8d_assemble
   import u8d_pkg::*;
   (
   input  logic      clock,
   input  logic      reset,
   input  logic      tok_valid,
   input  token_type tok,
   output logic      tok_pop,
   u8d_rsp_if.source rsp
);

   logic [REM_W-1:0] rem_ff, rem_in;
   logic [CP_W-1:0]  part_ff, part_in;
   logic [CP_W-1:0]  shifted;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CP_W-1:0]  code_ff;
   logic             status_ff;
   logic             emit;
   logic             emit_status;
   logic [CP_W-1:0]  emit_code;

   // A queued byte leaves as soon as the output register is free or being drained.
   assign tok_pop = tok_valid && (!rsp_valid_ff || rsp.ready);
   assign shifted = {part_ff[CP_W-7:0], tok.bits[5:0]};

   always_comb begin
      rem_in      = rem_ff;
      part_in     = part_ff;
      emit        = 1'b0;
      emit_status = STATUS_OK;
      emit_code   = '0;
      if (tok_pop) begin
         if (rem_ff == '0) begin
            unique case (tok.cls)
               CLS_ASCII: begin
                  emit      = 1'b1;
                  emit_code = CP_W'(tok.bits);
               end
               CLS_LEAD2, CLS_LEAD3, CLS_LEAD4: begin
                  unique case (tok.cls)
                     CLS_LEAD2: rem_in = REM_W'(1);
                     CLS_LEAD3: rem_in = REM_W'(2);
                     default:   rem_in = REM_W'(3);
                  endcase
                  part_in = CP_W'(tok.bits);
                  // A lead byte that ends the text leaves a truncated sequence.
                  if (tok.eot) begin
                     rem_in      = '0;
                     part_in     = '0;
                     emit        = 1'b1;
                     emit_status = STATUS_ERROR;
                  end
               end
               default: begin
                  emit        = 1'b1;
                  emit_status = STATUS_ERROR;
               end
            endcase
         end else if (tok.cls != CLS_CONT) begin
            rem_in      = '0;
            part_in     = '0;
            emit        = 1'b1;
            emit_status = STATUS_ERROR;
         end else if (rem_ff == REM_W'(1)) begin
            rem_in    = '0;
            part_in   = '0;
            emit      = 1'b1;
            emit_code = shifted;
         end else if (tok.eot) begin
            rem_in      = '0;
            part_in     = '0;
            emit        = 1'b1;
            emit_status = STATUS_ERROR;
         end else begin
            rem_in  = rem_ff - REM_W'(1);
            part_in = shifted;
         end
      end
   end

   always_comb begin
      if (tok_pop && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff       <= '0;
         part_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rem_ff       <= rem_in;
         part_ff      <= part_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tok_pop && emit) begin
         code_ff   <= emit_code;
         status_ff <= emit_status;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.code_point = code_ff;
   assign rsp.status     = status_ff;

   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      (rem_ff == '0) |-> (part_ff == '0))
      else $error("partial value left over with no sequence pending");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == STATUS_ERROR) |-> (code_ff == '0))
      else $error("error beat carries a nonzero code point");

endmodule

>>> hdl/utf8_stream_decoder.sv
// UTF-8 byte stream decoder: one byte per beat in, one code point or error beat out.
// Throughput: one byte per cycle while results are taken; the result register frees each cycle it is taken.
// The byte that completes or breaks a result is first stored in the QUEUE_DEPTH-entry queue,
// where it may wait behind a stalled output, and the result is then registered at the output.
// Reset (synchronous): queue emptied, no sequence pending, no result valid.
module utf8_stream_decoder
   import u8d_pkg::*;
   #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   u8d_req_if.sink   req,
   u8d_rsp_if.source rsp
);

   logic      push_valid;
   logic      push_ready;
   token_type push_token;
   logic      pop_valid;
   token_type pop_token;
   logic      pop;

   u8d_classify u_classify (
      .req        (req),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_token (push_token)
   );

   u8d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_token (push_token),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_token  (pop_token),
      .pop        (pop)
   );

   u8d_assemble u_assemble (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (pop_valid),
      .tok       (pop_token),
      .tok_pop   (pop),
      .rsp       (rsp)
   );

endmodule

>>> bench/utf8_stream_decoder_tb.sv
module utf8_stream_decoder_tb
   import u8d_pkg::*;
   ();

   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned DRAIN_CYCLES = 12;
   localparam int unsigned RANDOM_BYTES = 430;

   localparam logic [BYTE_W-1:0] CONT_MASK    = 8'hC0;
   localparam logic [BYTE_W-1:0] CONT_TAG     = 8'h80;
   localparam logic [BYTE_W-1:0] ASCII_LIMIT  = 8'h80;
   localparam logic [BYTE_W-1:0] LEAD3_MIN    = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD4_MIN    = 8'hF0;
   localparam logic [BYTE_W-1:0] BAD_LEAD_MIN = 8'hF8;

   typedef struct packed {
      logic [CP_W-1:0] code_point;
      logic            status;
   } decoded_char_type;

   typedef logic [BYTE_W-1:0] byte_queue_type[$];

   logic clock;
   logic reset;
   int unsigned cycle_count = 0;
   int unsigned mismatch_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned take_stall_pct = 0;

   // Decoder state as the predictor sees it.
   logic [REM_W-1:0] seq_left = '0;
   logic [CP_W-1:0]  seq_bits = '0;
   decoded_char_type pending_chars[$];

   u8d_req_if req_if ();
   u8d_rsp_if rsp_if ();

   utf8_stream_decoder i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic void note_char(input logic [CP_W-1:0] cp, input logic status);
      decoded_char_type entry;
      entry.code_point = cp;
      entry.status     = status;
      pending_chars.push_back(entry);
   endfunction

   function automatic void flag_malformed();
      seq_left = '0;
      seq_bits = '0;
      note_char('0, STATUS_ERROR);
   endfunction

   function automatic void decode_byte(input logic [BYTE_W-1:0] b, input logic eot);
      logic is_cont;
      is_cont = (b & CONT_MASK) == CONT_TAG;
      if (seq_left == 0) begin
         if (b < ASCII_LIMIT) begin
            note_char(CP_W'(b), STATUS_OK);
         end else if (is_cont || b >= BAD_LEAD_MIN) begin
            flag_malformed();
         end else begin
            if (b < LEAD3_MIN) begin
               seq_left = 2'd1;
               seq_bits = CP_W'(b[4:0]);
            end else if (b < LEAD4_MIN) begin
               seq_left = 2'd2;
               seq_bits = CP_W'(b[3:0]);
            end else begin
               seq_left = 2'd3;
               seq_bits = CP_W'(b[2:0]);
            end
            if (eot) flag_malformed();
         end
      end else if (!is_cont) begin
         // The offending byte is dropped along with the partial sequence.
         flag_malformed();
      end else begin
         seq_bits = {seq_bits[CP_W-7:0], b[5:0]};
         seq_left = seq_left - 1'b1;
         if (seq_left == 0) begin
            note_char(seq_bits, STATUS_OK);
            seq_bits = '0;
         end else if (eot) begin
            flag_malformed();
         end
      end
   endfunction

   // Drives result back-pressure, checks each result beat and predicts each byte beat.
   always @(posedge clock) begin : monitor
      decoded_char_type expected;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         seq_left = '0;
         seq_bits = '0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= take_stall_pct);
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_chars.size() == 0) begin
               $display("%0t: unexpected result: code point %h status %b", $time,
                        rsp_if.code_point, rsp_if.status);
               mismatch_count++;
            end else begin
               expected = pending_chars.pop_front();
               if (rsp_if.code_point !== expected.code_point) begin
                  $display("%0t: code point expected %h got %h", $time,
                           expected.code_point, rsp_if.code_point);
                  mismatch_count++;
               end
               if (rsp_if.status !== expected.status) begin
                  $display("%0t: status expected %b got %b", $time,
                           expected.status, rsp_if.status);
                  mismatch_count++;
               end
            end
         end
         if (req_if.valid && req_if.ready) decode_byte(req_if.data_byte, req_if.end_of_text);
      end
   end

   // Called just after a rising edge; returns at the edge where the beat is taken.
   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eot);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.data_byte   <= b;
      req_if.end_of_text <= eot;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic send_bytes(input byte_queue_type seq, input int eot_pos);
      foreach (seq[i]) send_byte(seq[i], i == eot_pos);
   endtask

   task automatic wait_for_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_chars.size() != 0) @(posedge clock);
      // Lead bytes leave no result, so they may still sit inside the block.
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [BYTE_W-1:0] lead_byte(input int unsigned conts);
      logic [BYTE_W-1:0] b;
      b = BYTE_W'($urandom_range(255));
      case (conts)
         1: b = {3'b110, b[4:0]};
         2: b = {4'b1110, b[3:0]};
         default: b = {5'b11110, b[2:0]};
      endcase
      return b;
   endfunction

   function automatic logic [BYTE_W-1:0] cont_byte();
      return {2'b10, 6'($urandom_range(63))};
   endfunction

   task automatic test_ascii_extremes();
      send_bytes('{8'h00, 8'h41}, -1);
      send_bytes('{8'h7F}, 0);
   endtask

   task automatic test_well_formed_sequences();
      send_bytes('{8'hC0, 8'h80}, -1);
      send_bytes('{8'hDF, 8'hBF}, 1);
      send_bytes('{8'hEF, 8'hBF, 8'hBF}, -1);
      send_bytes('{8'hF7, 8'hBF, 8'hBF, 8'hBF}, -1);
   endtask

   task automatic test_malformed_input();
      // Stray continuation, then invalid leads at both ends of their range.
      send_bytes('{8'h80, 8'hF8, 8'hFF}, -1);
      // The ASCII byte that breaks the sequence must not be decoded.
      send_bytes('{8'hC2, 8'h41}, -1);
      // Text ending on a lead byte, then on a middle continuation.
      send_bytes('{8'hF0}, 0);
      send_bytes('{8'hE2, 8'h82}, 1);
   endtask

   task automatic test_random_text(input int unsigned idle_pct, input int unsigned stall_pct,
                                   input int unsigned n_bytes);
      int unsigned sent;
      int unsigned roll;
      int unsigned conts;
      int eot_pos;
      logic [BYTE_W-1:0] b;
      byte_queue_type seq;
      send_idle_pct  = idle_pct;
      take_stall_pct = stall_pct;
      sent = 0;
      while (sent < n_bytes) begin
         seq.delete();
         roll = $urandom_range(99);
         if (roll < 30) begin
            seq.push_back(BYTE_W'($urandom_range(127)));
         end else if (roll < 84) begin
            conts = (roll < 50) ? 1 : (roll < 66) ? 2 : 3;
            seq.push_back(lead_byte(conts));
            repeat (conts) seq.push_back(cont_byte());
         end else if (roll < 90) begin
            seq.push_back(cont_byte());
         end else if (roll < 93) begin
            seq.push_back(BYTE_W'($urandom_range(255, 248)));
         end else begin
            // A sequence cut short by any byte that is not a continuation.
            conts = $urandom_range(3, 1);
            seq.push_back(lead_byte(conts));
            repeat ($urandom_range(conts - 1)) seq.push_back(cont_byte());
            b = BYTE_W'($urandom_range(255));
            if (b[7:6] == 2'b10) b[6] = 1'b1;
            seq.push_back(b);
         end
         eot_pos = -1;
         case ($urandom_range(15))
            0: eot_pos = seq.size() - 1;
            1: eot_pos = $urandom_range(seq.size() - 1);
            default: eot_pos = -1;
         endcase
         if (eot_pos >= 0) begin
            while (seq.size() > eot_pos + 1) void'(seq.pop_back());
         end
         send_bytes(seq, eot_pos);
         sent += seq.size();
      end
   endtask

   initial begin
      req_if.valid       <= 1'b0;
      req_if.data_byte   <= '0;
      req_if.end_of_text <= 1'b0;
      reset              <= 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_ascii_extremes();
      test_well_formed_sequences();
      test_malformed_input();
      wait_for_results();

      test_random_text(20, 83, RANDOM_BYTES);
      wait_for_results();
      test_random_text(83, 20, RANDOM_BYTES);
      test_random_text(0, 0, RANDOM_BYTES);
      wait_for_results();

      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

>>> files.f
hdl/u8d_pkg.sv
hdl/u8d_req_if.sv
hdl/u8d_rsp_if.sv
hdl/u8d_classify.sv
hdl/u8d_queue.sv
hdl/u8d_assemble.sv
hdl/utf8_stream_decoder.sv
bench/utf8_stream_decoder_tb.sv
